/* hdl/fcpu_pkg.sv */
// Package for the fly camera pose update block: constants, types and sine coefficients.
`default_nettype none
package fcpu_pkg;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam logic [11:0] CENTER_X_RST = 12'd400;
  localparam logic [11:0] CENTER_Y_RST = 12'd300;
  localparam logic [15:0] GAIN_RST     = 16'd64;
  localparam logic [23:0] SPEED_RST    = 24'd327680;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_GAIN     = 2'd2;
  localparam logic [1:0] REG_SPEED    = 2'd3;

  // Q30 polynomial coefficients for sin(pi/2*t)
  localparam logic [31:0] SIN_A = 32'd1686629713;
  localparam logic [31:0] SIN_B = 32'd693598668;
  localparam logic [31:0] SIN_C = 32'd85569305;
  localparam logic [31:0] SIN_D = 32'd5026995;
  localparam logic [31:0] SIN_E = 32'd172271;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DYAW,
    ST_DPITCH,
    ST_ANGLES,
    ST_STEP,
    ST_KEYS,
    ST_SIN_SETUP,
    ST_SIN_T2,
    ST_SIN_E,
    ST_SIN_D,
    ST_SIN_C,
    ST_SIN_B,
    ST_SIN_A,
    ST_SIN_END,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_POS,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

/* hdl/fly_camera_pose_update.sv */
// Top level of the fly camera pose update block: sequencer, shared multiplier, output register.
//
// A single shared 34x34 multiplier is stepped by a sequencer through the two
// angle products, the step product, two Horner sine evaluations (six products
// each) and four rotation products, one product per state. The angle update,
// the key decode, the two sine setup and end steps, the position update and
// the output load have states of their own. in_tready is low while an item is
// in work and while a result waits in the output register. A new item can be
// taken in the cycle after the result leaves, so the block takes no new item
// while one is in work. The first item after reset only marks the block
// started and returns the reset pose through the output load state.
`default_nettype none
module fly_camera_pose_update #(
  parameter int ANGLE_BITS    = fcpu_pkg::ANGLE_BITS_DEF,
  parameter int POSITION_BITS = fcpu_pkg::POSITION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cursor_x[11:0], cursor_y[23:12], delta_time[39:24], key_forward[40],
  // key_back[41], key_left[42], key_right[43], key_up[44], key_down[45]
  input  wire logic [47:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_pos_x[31:0], out_pos_y[63:32], out_pos_z[95:64], out_pitch[111:96],
  // out_yaw[127:112]
  output logic [127:0]      out_tdata
);
  localparam int AB = ANGLE_BITS;
  localparam int PB = POSITION_BITS;
  localparam int QB = AB - 2;
  localparam logic signed [AB:0] QUARTER = (AB+1)'(1) <<< QB;

  // config registers
  logic [11:0] center_x_r, center_y_r;
  logic [15:0] gain_r;
  logic [23:0] speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= fcpu_pkg::CENTER_X_RST;
      center_y_r <= fcpu_pkg::CENTER_Y_RST;
      gain_r     <= fcpu_pkg::GAIN_RST;
      speed_r    <= fcpu_pkg::SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcpu_pkg::REG_CENTER_X: center_x_r <= cfg_data[11:0];
        fcpu_pkg::REG_CENTER_Y: center_y_r <= cfg_data[11:0];
        fcpu_pkg::REG_GAIN:     gain_r     <= cfg_data[15:0];
        fcpu_pkg::REG_SPEED:    speed_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  fcpu_pkg::state_t state_r, state_nxt;

  // pose and work registers
  logic signed [AB-1:0] pitch_r, pitch_nxt;
  logic [AB-1:0]        yaw_r, yaw_nxt;
  logic signed [PB-1:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic                 started_r, started_nxt;
  logic [47:0]          item_r, item_nxt;
  logic signed [29:0]   dang_r, dang_nxt;      // angle deltas
  logic signed [29:0]   dpitch_r, dpitch_nxt;
  logic signed [40:0]   step_r, step_nxt;      // signed step magnitude
  logic signed [41:0]   fwd_r, str_r, fwd_nxt, str_nxt;
  logic signed [41:0]   fly_r, fly_nxt;
  logic                 cos_pass_r, cos_pass_nxt;
  logic [30:0]          t_r, t_nxt;
  logic [31:0]          t2_r, t2_nxt, acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [16:0]   sin_r, cos_r, sin_nxt, cos_nxt;
  logic signed [63:0]   sx_r, sz_r, sx_nxt, sz_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [127:0]         out_data_r, out_data_nxt;

  // shared multiplier: signed 34 x 34 operand slots, product 68 bits
  logic signed [33:0]   mul_a;
  logic signed [33:0]   mul_b;
  logic signed [67:0]   mul_p;
  assign mul_p = mul_a * mul_b;

  logic [AB-1:0]        ang;
  logic [1:0]           quad;
  logic [30:0]          tq;
  logic [75:0]          shr;
  logic [31:0]          rr;
  logic signed [64:0]   rnd;
  logic signed [PB+1:0] sum_x, sum_y, sum_z;

  function automatic logic signed [PB-1:0] sat(input logic signed [PB+1:0] v);
    logic signed [PB+1:0] hi;
    logic signed [PB+1:0] lo;
    hi = (PB+2)'((65'sd1 <<< (PB-1)) - 65'sd1);
    lo = -hi - (PB+2)'(1);
    if (v > hi) sat = hi[PB-1:0];
    else if (v < lo) sat = lo[PB-1:0];
    else sat = v[PB-1:0];
  endfunction

  function automatic logic signed [63:0] rshift15(input logic signed [64:0] v);
    rshift15 = 64'(v >>> 15);   // arithmetic shift is floor
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcpu_pkg::ST_IDLE;
      pitch_r     <= '0;
      yaw_r       <= '0;
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pitch_r     <= pitch_nxt;
      yaw_r       <= yaw_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pz_r        <= pz_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    dang_r     <= dang_nxt;
    dpitch_r   <= dpitch_nxt;
    step_r     <= step_nxt;
    fwd_r      <= fwd_nxt;
    str_r      <= str_nxt;
    fly_r      <= fly_nxt;
    cos_pass_r <= cos_pass_nxt;
    t_r        <= t_nxt;
    t2_r       <= t2_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    sin_r      <= sin_nxt;
    cos_r      <= cos_nxt;
    sx_r       <= sx_nxt;
    sz_r       <= sz_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == fcpu_pkg::ST_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    pitch_nxt    = pitch_r;
    yaw_nxt      = yaw_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    pz_nxt       = pz_r;
    started_nxt  = started_r;
    item_nxt     = item_r;
    dang_nxt     = dang_r;
    dpitch_nxt   = dpitch_r;
    step_nxt     = step_r;
    fwd_nxt      = fwd_r;
    str_nxt      = str_r;
    fly_nxt      = fly_r;
    cos_pass_nxt = cos_pass_r;
    t_nxt        = t_r;
    t2_nxt       = t2_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    sin_nxt      = sin_r;
    cos_nxt      = cos_r;
    sx_nxt       = sx_r;
    sz_nxt       = sz_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    mul_a        = '0;
    mul_b        = '0;
    ang          = cos_pass_r ? yaw_r + AB'(1 << QB) : yaw_r;
    quad         = ang[AB-1 -: 2];
    tq           = 31'({ang[QB-1:0]}) << (30 - QB);
    shr          = '0;
    rr           = '0;
    rnd          = '0;
    sum_x        = '0;
    sum_y        = '0;
    sum_z        = '0;

    case (state_r)
      fcpu_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          item_nxt = in_tdata;
          state_nxt = started_r ? fcpu_pkg::ST_DYAW : fcpu_pkg::ST_OUT;
          started_nxt = 1'b1;
        end
      end
      fcpu_pkg::ST_DYAW: begin
        mul_a = 34'($signed({1'b0, gain_r}));
        mul_b = 34'($signed({1'b0, center_x_r}) - $signed({1'b0, item_r[11:0]}));
        dang_nxt = 30'(mul_p >>> 8);
        state_nxt = fcpu_pkg::ST_DPITCH;
      end
      fcpu_pkg::ST_DPITCH: begin
        mul_a = 34'($signed({1'b0, gain_r}));
        mul_b = 34'($signed({1'b0, center_y_r}) - $signed({1'b0, item_r[23:12]}));
        dpitch_nxt = 30'(mul_p >>> 8);
        state_nxt = fcpu_pkg::ST_ANGLES;
      end
      fcpu_pkg::ST_ANGLES: begin
        // pitch: gain*offset fits 30 bits; pitch stays in +-quarter
        if (32'(dpitch_r) + 32'(pitch_r) > 32'(QUARTER)) pitch_nxt = QUARTER[AB-1:0];
        else if (32'(dpitch_r) + 32'(pitch_r) < -32'(QUARTER))
          pitch_nxt = AB'(-QUARTER);
        else pitch_nxt = AB'(32'(dpitch_r) + 32'(pitch_r));
        yaw_nxt = yaw_r + AB'(dang_r);
        state_nxt = fcpu_pkg::ST_STEP;
      end
      fcpu_pkg::ST_STEP: begin
        mul_a = 34'($signed({1'b0, item_r[39:24]}));
        mul_b = 34'($signed({1'b0, speed_r}));
        step_nxt = 41'(mul_p >>> 16);
        state_nxt = fcpu_pkg::ST_KEYS;
      end
      fcpu_pkg::ST_KEYS: begin
        fwd_nxt = (item_r[41] ? 42'(step_r) : 42'sd0) - (item_r[40] ? 42'(step_r) : 42'sd0);
        str_nxt = (item_r[43] ? 42'(step_r) : 42'sd0) - (item_r[42] ? 42'(step_r) : 42'sd0);
        fly_nxt = (item_r[44] ? 42'(step_r) : 42'sd0) - (item_r[45] ? 42'(step_r) : 42'sd0);
        cos_pass_nxt = 1'b0;
        state_nxt = fcpu_pkg::ST_SIN_SETUP;
      end
      fcpu_pkg::ST_SIN_SETUP: begin
        t_nxt = quad[0] ? (31'd1 << 30) - tq : tq;
        neg_nxt = quad[1];
        state_nxt = fcpu_pkg::ST_SIN_T2;
      end
      fcpu_pkg::ST_SIN_T2: begin
        mul_a = 34'($signed({1'b0, t_r}));
        mul_b = 34'($signed({1'b0, t_r}));
        shr = 76'(mul_p) >> 30;
        t2_nxt = shr[31:0];
        state_nxt = fcpu_pkg::ST_SIN_E;
      end
      fcpu_pkg::ST_SIN_E: begin
        mul_a = 34'($signed({1'b0, t2_r}));
        mul_b = 34'($signed({1'b0, fcpu_pkg::SIN_E}));
        shr = 76'(mul_p) >> 30;
        acc_nxt = fcpu_pkg::SIN_D - shr[31:0];
        state_nxt = fcpu_pkg::ST_SIN_D;
      end
      fcpu_pkg::ST_SIN_D, fcpu_pkg::ST_SIN_C, fcpu_pkg::ST_SIN_B: begin
        mul_a = 34'($signed({1'b0, t2_r}));
        mul_b = 34'($signed({1'b0, acc_r}));
        shr = 76'(mul_p) >> 30;
        if (state_r == fcpu_pkg::ST_SIN_D) begin
          acc_nxt = fcpu_pkg::SIN_C - shr[31:0];
          state_nxt = fcpu_pkg::ST_SIN_C;
        end else if (state_r == fcpu_pkg::ST_SIN_C) begin
          acc_nxt = fcpu_pkg::SIN_B - shr[31:0];
          state_nxt = fcpu_pkg::ST_SIN_B;
        end else begin
          acc_nxt = fcpu_pkg::SIN_A - shr[31:0];
          state_nxt = fcpu_pkg::ST_SIN_A;
        end
      end
      fcpu_pkg::ST_SIN_A: begin
        mul_a = 34'($signed({1'b0, t_r}));
        mul_b = 34'($signed({1'b0, acc_r}));
        shr = (76'(mul_p) + (76'd1 << 44)) >> 45;
        rr = (shr > 76'd32767) ? 32'd32767 : shr[31:0];
        acc_nxt = rr;
        state_nxt = fcpu_pkg::ST_SIN_END;
      end
      fcpu_pkg::ST_SIN_END: begin
        if (cos_pass_r) begin
          cos_nxt = neg_r ? -$signed({1'b0, acc_r[15:0]}) : $signed({1'b0, acc_r[15:0]});
          state_nxt = fcpu_pkg::ST_M0;
        end else begin
          sin_nxt = neg_r ? -$signed({1'b0, acc_r[15:0]}) : $signed({1'b0, acc_r[15:0]});
          cos_pass_nxt = 1'b1;
          state_nxt = fcpu_pkg::ST_SIN_SETUP;
        end
      end
      fcpu_pkg::ST_M0: begin
        mul_a = 34'(fwd_r);
        mul_b = 34'(sin_r);
        sx_nxt = 64'(mul_p);
        state_nxt = fcpu_pkg::ST_M1;
      end
      fcpu_pkg::ST_M1: begin
        mul_a = 34'(str_r);
        mul_b = 34'(cos_r);
        sx_nxt = sx_r + 64'(mul_p);
        state_nxt = fcpu_pkg::ST_M2;
      end
      fcpu_pkg::ST_M2: begin
        mul_a = 34'(fwd_r);
        mul_b = 34'(cos_r);
        sz_nxt = 64'(mul_p);
        state_nxt = fcpu_pkg::ST_M3;
      end
      fcpu_pkg::ST_M3: begin
        mul_a = 34'(str_r);
        mul_b = 34'(sin_r);
        sz_nxt = sz_r - 64'(mul_p);
        state_nxt = fcpu_pkg::ST_POS;
      end
      fcpu_pkg::ST_POS: begin
        // round x and z, then add and saturate each coordinate
        rnd = 65'(sx_r) + 65'sd16384;
        sum_x = (PB+2)'(px_r) + (PB+2)'(rshift15(rnd));
        rnd = 65'(sz_r) + 65'sd16384;
        sum_z = (PB+2)'(pz_r) + (PB+2)'(rshift15(rnd));
        sum_y = (PB+2)'(py_r) + (PB+2)'(fly_r);
        px_nxt = sat(sum_x);
        py_nxt = sat(sum_y);
        pz_nxt = sat(sum_z);
        state_nxt = fcpu_pkg::ST_OUT;
      end
      fcpu_pkg::ST_OUT: begin
        out_data_nxt = {16'(yaw_r), 16'(pitch_r), 32'(pz_r), 32'(py_r), 32'(px_r)};
        out_valid_nxt = 1'b1;
        state_nxt = fcpu_pkg::ST_IDLE;
      end
      default: state_nxt = fcpu_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire
